[rtl/arf_pkg.sv]
// shared types and constants for the amplicon region finder
package arf_pkg;

  localparam int COUNT_W  = 24;
  localparam int TOTAL_W  = 26;
  localparam int TRIPLE_W = 28;
  localparam int OUT_POS_W = 28;
  localparam int SNP_W    = 13;
  localparam int RECIP_W  = 27;
  localparam int RECIP_SHIFT = 29;
  // ceil(2^29 / 5), exact for dividends below 2^26
  localparam logic [RECIP_W-1:0] RECIP_FIVE = 27'd107374183;
  localparam logic [SNP_W-1:0] SNP_MAX = 13'd8191;
  localparam logic [TOTAL_W-1:0] MIN_COV_RST = 26'd100;

  typedef struct packed {
    logic [COUNT_W-1:0] t;
    logic [COUNT_W-1:0] g;
    logic [COUNT_W-1:0] c;
    logic [COUNT_W-1:0] a;
  } counts_t;

  typedef enum logic [3:0] {
    ST_STREAM,
    ST_PEAK,
    ST_TS_RD,
    ST_TS_CHK,
    ST_TE_RD,
    ST_TE_CHK,
    ST_MV_RD,
    ST_MV_CHK,
    ST_DIV,
    ST_SNP,
    ST_DONE
  } state_t;

  function automatic logic [TOTAL_W-1:0] total_of(counts_t e);
    total_of = TOTAL_W'(e.a) + TOTAL_W'(e.c) + TOTAL_W'(e.g) + TOTAL_W'(e.t);
  endfunction

endpackage

[rtl/arf_store.sv]
// region buffer: one write port, one read port, registered read data
module arf_store
  import arf_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  counts_t       wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output counts_t       rd_data
);

  counts_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/amplicon_region_finder.sv]
// amplicon region finder: top level
//
// s_* carries one genome position per beat (four base counts); positions are
// numbered from 0 in arrival order. cfg_* writes min_cov, taken at any time
// the block is idle. m_* carries one region record per closed region.
// a position is taken every cycle while positions stream in. a beat whose
// total is zero closes an open region; s_tready then drops while the buffer
// is walked: a peak scan over all n stored positions, a read and a check for
// each position checked at either end (every trimmed one plus the one that
// stops the trim), a read of the end total, the variant threshold formed from
// it (15/100 as times 3/4 then a reciprocal multiply by 1/5), an SNP scan
// from s to e and the load of the record.
// all walks go through the single read port of the region buffer.
// the record sits in an output register; streaming resumes at once unless
// an earlier record still waits, in which case both the load and streaming wait for it.
// reset clears the position counter, closes any region, sets min_cov to 100
// and drops m_tvalid; buffer contents are left as they are.
// a region still open when the stream stops gives no record.
module amplicon_region_finder
  import arf_pkg::*;
#(
  parameter int REGION_DEPTH  = 4096,
  parameter int POSITION_BITS = 28
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // count_a, count_c, count_g, count_t
  output logic         m_tvalid,
  input  logic         m_tready,
  // region_start, region_end, peak_coverage, snp_count, first_snp, buffer_overflow
  output logic [127:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [25:0]  cfg_data
);

  localparam int AW = $clog2(REGION_DEPTH);
  localparam int IW = $clog2(REGION_DEPTH + 1);
  localparam logic [IW-1:0] DEPTH_I = IW'(REGION_DEPTH);

  state_t state, state_next;

  logic [TOTAL_W-1:0] min_cov;
  logic [POSITION_BITS-1:0] pos;
  logic region_open;
  logic [POSITION_BITS-1:0] open_start;
  logic [IW-1:0] fill_count;
  logic overflowed;

  logic [IW-1:0] j, jd, s, e;
  logic vd;
  logic [TOTAL_W-1:0] peak;
  logic [TOTAL_W-1:0] qtr;
  logic [COUNT_W-1:0] quo;
  logic [SNP_W-1:0] snps;
  logic [POSITION_BITS-1:0] first;

  counts_t in_cnt, rd_data;
  logic [TOTAL_W-1:0] in_sum, rd_sum;
  logic accept, wr_en, rd_en;
  logic [AW-1:0] rd_addr;
  logic trim_hit;
  logic out_free;
  logic [TRIPLE_W-1:0] triple;
  logic [TOTAL_W+RECIP_W-1:0] prod;
  logic [2:0] hits;
  logic [POSITION_BITS-1:0] snp_pos, start_pos, end_pos;

  assign in_cnt.a = s_tdata[23:0];
  assign in_cnt.c = s_tdata[47:24];
  assign in_cnt.g = s_tdata[71:48];
  assign in_cnt.t = s_tdata[95:72];
  assign in_sum = total_of(in_cnt);
  assign rd_sum = total_of(rd_data);

  assign cfg_ready = 1'b1;
  assign s_tready = (state == ST_STREAM);
  assign accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign wr_en = accept && ((region_open && in_sum != '0 && fill_count < DEPTH_I) ||
                            (!region_open && in_sum >= min_cov));

  arf_store #(.DEPTH(REGION_DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (region_open ? fill_count[AW-1:0] : '0),
    .wr_data (in_cnt),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // {total,0} < peak without a wider multiply
  assign trim_hit = {rd_sum, 1'b0} < {1'b0, peak};
  assign triple = TRIPLE_W'(rd_sum) + TRIPLE_W'({rd_sum, 1'b0});
  assign prod = (TOTAL_W + RECIP_W)'(qtr) * (TOTAL_W + RECIP_W)'(RECIP_FIVE);
  assign hits = 3'(rd_data.a >= quo) + 3'(rd_data.c >= quo) +
                3'(rd_data.g >= quo) + 3'(rd_data.t >= quo);
  assign snp_pos   = open_start + POSITION_BITS'(jd);
  assign start_pos = open_start + POSITION_BITS'(s);
  assign end_pos   = open_start + POSITION_BITS'(e);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_STREAM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en = 1'b0;
    rd_addr = j[AW-1:0];
    case (state)
      ST_STREAM: begin
        if (accept && region_open && in_sum == '0) begin
          state_next = ST_PEAK;
        end
      end
      ST_PEAK: begin
        rd_en = (j < fill_count);
        if (j >= fill_count && !vd) begin
          state_next = ST_TS_RD;
        end
      end
      ST_TS_RD: begin
        rd_en = 1'b1;
        rd_addr = s[AW-1:0];
        state_next = ST_TS_CHK;
      end
      ST_TS_CHK: begin
        state_next = (s < e && trim_hit) ? ST_TS_RD : ST_TE_RD;
      end
      ST_TE_RD: begin
        rd_en = 1'b1;
        rd_addr = e[AW-1:0];
        state_next = ST_TE_CHK;
      end
      ST_TE_CHK: begin
        state_next = (e > s && trim_hit) ? ST_TE_RD : ST_MV_RD;
      end
      ST_MV_RD: begin
        rd_en = 1'b1;
        rd_addr = e[AW-1:0];
        state_next = ST_MV_CHK;
      end
      ST_MV_CHK: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        state_next = ST_SNP;
      end
      ST_SNP: begin
        rd_en = (j <= e);
        if (j > e && !vd) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_STREAM;
        end
      end
      default: state_next = ST_STREAM;
    endcase
  end

  // stream-side control state
  always_ff @(posedge clk) begin
    if (rst) begin
      min_cov <= MIN_COV_RST;
      pos <= '0;
      region_open <= 1'b0;
      open_start <= '0;
      fill_count <= '0;
      overflowed <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_cov <= cfg_data;
      end
      if (accept) begin
        pos <= pos + 1'b1;
        if (region_open) begin
          if (in_sum == '0) begin
            region_open <= 1'b0;
          end else if (fill_count < DEPTH_I) begin
            fill_count <= fill_count + 1'b1;
          end else begin
            overflowed <= 1'b1;
          end
        end else if (in_sum >= min_cov) begin
          region_open <= 1'b1;
          open_start <= pos;
          fill_count <= IW'(1);
          overflowed <= 1'b0;
        end
      end
    end
  end

  // analysis datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      vd <= rd_en && (state == ST_PEAK || state == ST_SNP);
      jd <= j;
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_STREAM: begin
          j <= '0;
          peak <= '0;
        end
        ST_PEAK: begin
          if (rd_en) begin
            j <= j + 1'b1;
          end
          if (vd && rd_sum > peak) begin
            peak <= rd_sum;
          end
          s <= '0;
          e <= fill_count - 1'b1;
        end
        ST_TS_CHK: begin
          if (s < e && trim_hit) begin
            s <= s + 1'b1;
          end
        end
        ST_TE_CHK: begin
          if (e > s && trim_hit) begin
            e <= e - 1'b1;
          end
        end
        ST_MV_CHK: begin
          // floor(3 * total / 4), divided by 5 in the next cycle
          qtr <= triple[TRIPLE_W-1:2];
        end
        ST_DIV: begin
          quo <= prod[RECIP_SHIFT +: COUNT_W];
          j <= s;
          snps <= '0;
          first <= '0;
        end
        ST_SNP: begin
          if (rd_en) begin
            j <= j + 1'b1;
          end
          if (vd && hits > 3'd1) begin
            if (snps == '0) begin
              first <= snp_pos;
            end
            if (snps < SNP_MAX) begin
              snps <= snps + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tdata <= {4'b0, overflowed,
                        OUT_POS_W'(32'(first)), snps, peak,
                        OUT_POS_W'(32'(end_pos)), OUT_POS_W'(32'(start_pos))};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/arf_checker.sv]
// port-level checks for the amplicon region finder
module arf_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("record dropped while stalled");

  a_first: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[94:82] == 13'd0 |-> m_tdata[122:95] == 28'd0)
    else $error("first snp set with no snps");

  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("reset did not clear output");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[127:124] == 4'd0)
    else $error("padding bits set");

endmodule

bind amplicon_region_finder arf_checker u_arf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
